// ===== hdl/deq_pkg.sv =====
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } fsm_t;

  typedef logic signed [DATA_W-1:0] word_t;

endpackage

// ===== hdl/deq_ifs.sv =====
interface deq_in_if;
  import deq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic signed [DATA_W-1:0] data;
  logic                last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ===== hdl/double_ended_queue.sv =====
// Push and pop: one beat per cycle while the output is free; result registered the cycle after.
// Dump of n entries: n beats from the front cell as the row rotates, one per cycle while the
// output is free; input is held off until the final dump beat has left the output register.
// Dump of an empty queue, or a full/empty reject: a single beat, registered like a push or pop.
// Reset (rst_n low, synchronous) empties the queue and clears the output valid;
// stored words are not cleared and are read only after being written.
module double_ended_queue (
  input logic      clk,
  input logic      rst_n,
  deq_in_if.sink   in_ch,
  deq_out_if.source out_ch
);
  import deq_pkg::*;

  word_t             cell_q  [DEPTH];
  cell_op_t          cell_op [DEPTH];
  word_t             load_data;

  fsm_t              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_m1;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  word_t             data_r, data_nxt;
  logic              last_r, last_nxt;

  logic              slot_free;
  logic              in_rdy;
  logic              in_fire;
  logic              is_full;
  logic              is_empty;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      word_t left_d;
      word_t right_d;
      if (g == 0) begin : g_first
        assign left_d = cell_q[g];
      end else begin : g_mid_l
        assign left_d = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_end
        assign right_d = cell_q[g];
      end else begin : g_mid_r
        assign right_d = cell_q[g+1];
      end
      deq_cell u_cell (
        .clk     (clk),
        .op      (cell_op[g]),
        .left_d  (left_d),
        .right_d (right_d),
        .load_d  (load_data),
        .q       (cell_q[g])
      );
    end
  endgenerate

  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_rdy    = rst_n && (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_ch.valid && in_rdy;
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign cnt_m1    = count_r - 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.operation == OP_DUMP) && !is_empty) begin
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        if (slot_free && (rem_r == CNT_W'(1))) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control and result beat
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
    end
    load_data     = in_ch.value;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    data_nxt      = data_r;
    last_nxt      = last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.operation)
            OP_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              data_nxt      = '0;
              last_nxt      = 1'b1;
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                status_nxt = ST_OK;
                for (int i = 0; i < DEPTH; i++) begin
                  cell_op[i] = CELL_FROM_LEFT;
                end
                cell_op[0] = CELL_LOAD;
                count_nxt  = count_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              data_nxt      = '0;
              last_nxt      = 1'b1;
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                status_nxt                    = ST_OK;
                cell_op[count_r[IDX_W-1:0]]   = CELL_LOAD;
                count_nxt                     = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              out_valid_nxt = 1'b1;
              data_nxt      = '0;
              last_nxt      = 1'b1;
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                status_nxt = ST_OK;
                for (int i = 0; i < DEPTH; i++) begin
                  cell_op[i] = CELL_FROM_RIGHT;
                end
                count_nxt = cnt_m1;
              end
            end
            OP_POP_BACK: begin
              out_valid_nxt = 1'b1;
              data_nxt      = '0;
              last_nxt      = 1'b1;
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                status_nxt = ST_OK;
                count_nxt  = cnt_m1;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_EMPTY;
                data_nxt      = '0;
                last_nxt      = 1'b1;
              end else begin
                rem_nxt = count_r;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          // rotate left: front leaves on the beat and re-enters at the back
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          data_nxt      = cell_q[0];
          last_nxt      = (rem_r == CNT_W'(1));
          for (int i = 0; i < DEPTH; i++) begin
            cell_op[i] = CELL_FROM_RIGHT;
          end
          load_data                  = cell_q[0];
          cell_op[cnt_m1[IDX_W-1:0]] = CELL_LOAD;
          rem_nxt                    = rem_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    data_r   <= data_nxt;
    last_r   <= last_nxt;
  end

  assign in_ch.ready   = in_rdy;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.data   = data_r;
  assign out_ch.last   = last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_dump_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> ((rem_r != '0) && (rem_r <= count_r)))
    else $error("dump beat counter out of range");

  a_dump_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> !in_ch.ready)
    else $error("input taken during dump");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_full &&
     ((in_ch.operation == OP_PUSH_FRONT) || (in_ch.operation == OP_PUSH_BACK)))
    |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not grow the queue");

  a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |=> (count_r == $past(count_r)))
    else $error("count changed during dump");

endmodule

// ===== hdl/deq_cell.sv =====
module deq_cell (
  input  logic              clk,
  input  deq_pkg::cell_op_t op,
  input  deq_pkg::word_t    left_d,
  input  deq_pkg::word_t    right_d,
  input  deq_pkg::word_t    load_d,
  output deq_pkg::word_t    q
);
  import deq_pkg::*;

  word_t q_r;

  always_ff @(posedge clk) begin
    case (op)
      CELL_FROM_LEFT:  q_r <= left_d;
      CELL_FROM_RIGHT: q_r <= right_d;
      CELL_LOAD:       q_r <= load_d;
      default:         q_r <= q_r;
    endcase
  end

  assign q = q_r;

endmodule
